// File: hdl/linear_fade_and_lfo_generator_assert.svh
// assertion macros shared by the fader sources
// needs nothing else; files that check their own logic include it by bare name
`ifndef LINEAR_FADE_AND_LFO_GENERATOR_ASSERT_SVH
`define LINEAR_FADE_AND_LFO_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
// property on an explicit clock and active-low reset
`define LFG_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// property on the usual clk_i / rst_ni of the enclosing module
`define LFG_ASSERT(lbl, prop, msg) \
  `LFG_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)
`else
`define LFG_ASSERT_AT(lbl, clk, rstn, prop, msg)
`define LFG_ASSERT(lbl, prop, msg)
`endif

`endif

// File: hdl/lfg_pkg.sv
// types, widths, codes and the quarter-wave sine table of the fader
// no dependencies; used by every module of the block
package lfg_pkg;

  localparam int LEVEL_BITS    = 16;
  localparam int TIME_BITS     = 32;
  localparam int SINE_DEPTH    = 256;
  localparam int SINE_IDX_BITS = $clog2(SINE_DEPTH);
  localparam int PHASE_BITS    = SINE_IDX_BITS + 2;
  localparam int SINE_BITS     = 16;
  localparam int SINE_SHIFT    = SINE_BITS - 1;
  localparam int SINE_PEAK     = (1 << SINE_SHIFT) - 1;
  localparam int SINE_TERMS    = 6;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // level differences and sums need one extra bit
  localparam int DIFF_BITS = LEVEL_BITS + 1;
  localparam int SAT_BITS  = LEVEL_BITS + 4;
  localparam int NUM_BITS  = DIFF_BITS + SINE_SHIFT + 3;

  // shift-add multiplier: time-wide multiplicand, difference-wide multiplier
  localparam int MUL_A_BITS   = TIME_BITS;
  localparam int MUL_B_BITS   = DIFF_BITS;
  localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam int MUL_CNT_BITS = $clog2(MUL_B_BITS + 1);

  // restoring divider
  localparam int DIV_N_BITS   = MUL_P_BITS;
  localparam int DIV_D_BITS   = TIME_BITS;
  localparam int DIV_Q_BITS   = TIME_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_Q_BITS + 1);

  // quotient bits needed by each division
  localparam int ITER_REANCHOR = TIME_BITS;
  localparam int ITER_FADE     = DIFF_BITS;
  localparam int ITER_MOD      = TIME_BITS;
  localparam int ITER_PHASE    = PHASE_BITS;
  localparam int ITER_LFO      = LEVEL_BITS + 2;
  localparam int LFO_DIVISOR   = 2 * SINE_PEAK;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = TIME_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_LEVEL = 3'd0,
    CFG_END_LEVEL   = 3'd1,
    CFG_DURATION    = 3'd2,
    CFG_START_TIME  = 3'd3,
    CFG_LFO_MODE    = 3'd4
  } cfg_index_e;

  typedef enum logic [1:0] {
    FS_DISABLED = 2'd0,
    FS_FADING   = 2'd1,
    FS_STOPPED  = 2'd2,
    FS_LFO      = 2'd3
  } fader_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RA_MUL,
    ST_RA_DIV,
    ST_FADE_CHK,
    ST_FADE_MUL,
    ST_FADE_DIV,
    ST_LFO_MOD,
    ST_LFO_PH,
    ST_LFO_MUL,
    ST_LFO_DIV,
    ST_EMIT
  } lfg_state_e;

  typedef struct packed {
    logic                  command;
    logic [TIME_BITS-1:0]  now_time;
  } lfg_in_t;

  typedef struct packed {
    logic signed [LEVEL_BITS-1:0] level;
    fader_state_e                 fader_state;
  } lfg_out_t;

  typedef struct packed {
    logic                  start;
    logic [MUL_A_BITS-1:0] a;
    logic [MUL_B_BITS-1:0] b;
  } lfg_mul_req_t;

  typedef struct packed {
    logic                  done;
    logic [MUL_P_BITS-1:0] product;
  } lfg_mul_rsp_t;

  typedef struct packed {
    logic                    start;
    logic [DIV_N_BITS-1:0]   dividend;
    logic [DIV_D_BITS-1:0]   divisor;
    logic [DIV_CNT_BITS-1:0] iters;
  } lfg_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_Q_BITS-1:0] quotient;
    logic [DIV_D_BITS-1:0] remainder;
  } lfg_div_rsp_t;

  typedef logic [SINE_DEPTH-1:0][SINE_BITS-1:0] sine_table_t;

  // Taylor series in Q30, rounded to the sine peak
  function automatic sine_table_t build_sine_table();
    sine_table_t tbl;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_DEPTH;
      sum  = x;
      term = x;
      for (int k = 1; k <= SINE_TERMS; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'(SINE_PEAK) + (64'd1 << 29)) >> 30;
      if (v > 64'(SINE_PEAK)) begin
        v = 64'(SINE_PEAK);
      end
      tbl[i] = SINE_BITS'(v);
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

  localparam logic signed [SAT_BITS-1:0] SAT_MAX = SAT_BITS'((1 << (LEVEL_BITS - 1)) - 1);
  localparam logic signed [SAT_BITS-1:0] SAT_MIN = -SAT_MAX - SAT_BITS'(1);

  function automatic logic signed [LEVEL_BITS-1:0] sat_level(
    input logic signed [SAT_BITS-1:0] v
  );
    logic signed [SAT_BITS-1:0] c;
    c = v;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end
    return LEVEL_BITS'(c);
  endfunction

endpackage

// File: hdl/lfg_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on lfg_pkg
module lfg_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lfg_pkg::lfg_mul_req_t req_i,
  output lfg_pkg::lfg_mul_rsp_t rsp_o
);
  import lfg_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [MUL_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [MUL_A_BITS-1:0]   a_q, a_d;
  logic [MUL_P_BITS-1:0]   p_q, p_d;
  logic [MUL_A_BITS:0]     partial;

  // upper half plus the multiplicand when the low bit is set
  assign partial = {1'b0, p_q[MUL_P_BITS-1:MUL_B_BITS]} +
                   (p_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    p_d    = p_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = MUL_CNT_BITS'(MUL_B_BITS);
      a_d    = req_i.a;
      p_d    = {{MUL_A_BITS{1'b0}}, req_i.b};
    end else if (busy_q) begin
      p_d   = {partial, p_q[MUL_B_BITS-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MUL_CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = p_q;

endmodule

// File: hdl/lfg_div.sv
// restoring divider, one quotient bit per cycle, quotient length set per request
// depends on lfg_pkg and the assertion macro header
`include "linear_fade_and_lfo_generator_assert.svh"

module lfg_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lfg_pkg::lfg_div_req_t req_i,
  output lfg_pkg::lfg_div_rsp_t rsp_o
);
  import lfg_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DIV_D_BITS-1:0]   div_q, div_d;
  logic [DIV_D_BITS-1:0]   rem_q, rem_d;
  logic [DIV_N_BITS-1:0]   nq_q, nq_d;
  logic [DIV_Q_BITS-1:0]   quo_q, quo_d;
  logic [DIV_N_BITS-1:0]   shifted_full;
  logic [DIV_CNT_BITS-1:0] align_shamt;
  logic [DIV_D_BITS:0]     trial;
  logic [DIV_D_BITS:0]     trial_diff;
  logic                    fits;

  // the caller guarantees the quotient fits in iters bits,
  // so the bits above iters already sit below the divisor
  assign shifted_full = req_i.dividend >> req_i.iters;
  assign align_shamt  = DIV_CNT_BITS'(DIV_N_BITS) - req_i.iters;

  assign trial      = {rem_q, nq_q[DIV_N_BITS-1]};
  assign trial_diff = trial - {1'b0, div_q};
  assign fits       = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    nq_d   = nq_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      div_d  = req_i.divisor;
      rem_d  = shifted_full[DIV_D_BITS-1:0];
      nq_d   = req_i.dividend << align_shamt;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? trial_diff[DIV_D_BITS-1:0] : trial[DIV_D_BITS-1:0];
      quo_d = {quo_q[DIV_Q_BITS-2:0], fits};
      nq_d  = {nq_q[DIV_N_BITS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    nq_q  <= nq_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  `LFG_ASSERT(a_div_start_idle, req_i.start |-> !busy_q, "divider restarted while busy")
  `LFG_ASSERT(a_div_iters_range, req_i.start |-> (req_i.iters != '0 && req_i.iters <= DIV_CNT_BITS'(DIV_Q_BITS)), "divider quotient length out of range")
  `LFG_ASSERT(a_div_quot_fits, req_i.start |-> (shifted_full < DIV_N_BITS'(req_i.divisor)), "divider quotient wider than requested")

endmodule

// File: hdl/linear_fade_and_lfo_generator.sv
// start, stopped and disabled words skip the arithmetic; a fade sample runs up to a
// multiply and a divide, maybe after another pair when time stepped back; an lfo sample
// runs a multiply and up to three divides; one word in flight, next word taken in the
// cycle after the result is registered; shared bit-serial multiplier and divider (one
// bit/cycle); rst_ni clears config, fader state and handshakes at once; sine table constant
// depends on lfg_pkg, lfg_mul, lfg_div and the assertion macro header
`include "linear_fade_and_lfo_generator_assert.svh"

module linear_fade_and_lfo_generator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample / start words
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  lfg_pkg::lfg_in_t                     in_word_i,
  // level words
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output lfg_pkg::lfg_out_t                    out_word_o,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [lfg_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [lfg_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i
);
  import lfg_pkg::*;

  // configuration registers
  logic signed [LEVEL_BITS-1:0] start_level_q;
  logic signed [LEVEL_BITS-1:0] end_level_q;
  logic [TIME_BITS-1:0]         duration_q;
  logic [TIME_BITS-1:0]         start_time_q;
  logic                         lfo_mode_q;

  // sequencer and fader state
  lfg_state_e                   state_q, state_d;
  fader_state_e                 mode_q, mode_d;
  logic signed [LEVEL_BITS-1:0] anchor_level_q, anchor_level_d;
  logic signed [LEVEL_BITS-1:0] current_level_q, current_level_d;
  logic [TIME_BITS-1:0]         anchor_time_q, anchor_time_d;
  logic [TIME_BITS-1:0]         remaining_q, remaining_d;

  // word being worked on
  logic                         cmd_q;
  logic [TIME_BITS-1:0]         now_q;
  logic signed [LEVEL_BITS-1:0] lvl_q, lvl_d;
  logic                         sine_neg_q, sine_neg_d;
  logic                         num_neg_q, num_neg_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  lfg_out_t                     out_word_q;

  // shared arithmetic units
  lfg_mul_req_t                 mul_req;
  lfg_mul_rsp_t                 mul_rsp;
  lfg_div_req_t                 div_req;
  lfg_div_rsp_t                 div_rsp;

  // datapath helpers
  logic signed [DIFF_BITS-1:0]  to_cur, to_anchor, span, sum_ab;
  logic [DIFF_BITS-1:0]         un, ud, h;
  logic [TIME_BITS-1:0]         el_fade, el_lfo;
  logic                         in_accept, out_free;
  logic                         back_in_time, ratio_ok, ra_div, fade_stop, per_zero;
  logic [PHASE_BITS-1:0]        phase;
  logic [SINE_IDX_BITS-1:0]     sine_idx, mirror_idx;
  logic [SINE_BITS-1:0]         sine_mag;
  logic [DIFF_BITS-1:0]         m_fade;
  logic signed [SAT_BITS-1:0]   m_ext, fade_sum;
  logic signed [NUM_BITS-1:0]   ab_scaled, hs, lfo_num;
  logic [NUM_BITS-1:0]          lfo_mag;
  logic [ITER_LFO-1:0]          lfo_q;
  logic signed [SAT_BITS-1:0]   lfo_q_adj;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // configuration port, to be written only while idle; the block itself does not enforce this
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_level_q <= '0;
      end_level_q   <= '0;
      duration_q    <= '0;
      start_time_q  <= '0;
      lfo_mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_LEVEL: start_level_q <= signed'(cfg_wdata_i[LEVEL_BITS-1:0]);
        CFG_END_LEVEL:   end_level_q   <= signed'(cfg_wdata_i[LEVEL_BITS-1:0]);
        CFG_DURATION:    duration_q    <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_START_TIME:  start_time_q  <= cfg_wdata_i[TIME_BITS-1:0];
        CFG_LFO_MODE:    lfo_mode_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // level arithmetic
  // ---------------------------------------------------------------------------
  // distances to the target, from the live end level
  assign to_cur    = DIFF_BITS'(end_level_q) - DIFF_BITS'(current_level_q);
  assign to_anchor = DIFF_BITS'(end_level_q) - DIFF_BITS'(anchor_level_q);
  assign span      = DIFF_BITS'(end_level_q) - DIFF_BITS'(start_level_q);
  assign sum_ab    = DIFF_BITS'(end_level_q) + DIFF_BITS'(start_level_q);
  assign un = to_cur[DIFF_BITS-1]    ? DIFF_BITS'(-to_cur)    : DIFF_BITS'(to_cur);
  assign ud = to_anchor[DIFF_BITS-1] ? DIFF_BITS'(-to_anchor) : DIFF_BITS'(to_anchor);
  assign h  = span[DIFF_BITS-1]      ? DIFF_BITS'(-span)      : DIFF_BITS'(span);

  assign back_in_time = (now_q < anchor_time_q);
  // remaining time shrinks by how much of the span is still ahead
  assign ratio_ok = (to_cur != '0) && (to_anchor != '0) &&
                    (to_cur[DIFF_BITS-1] == to_anchor[DIFF_BITS-1]);
  assign ra_div   = ratio_ok && (un < ud);

  assign el_fade   = now_q - anchor_time_q;
  assign el_lfo    = back_in_time ? '0 : now_q - anchor_time_q;
  assign fade_stop = (remaining_q == '0) || (el_fade > remaining_q);
  assign per_zero  = (remaining_q == '0);

  // fade step: anchor plus the scaled distance, toward the target
  assign m_fade   = div_rsp.quotient[DIFF_BITS-1:0];
  assign m_ext    = signed'({{(SAT_BITS - DIFF_BITS){1'b0}}, m_fade});
  assign fade_sum = SAT_BITS'(anchor_level_q) + (to_anchor[DIFF_BITS-1] ? -m_ext : m_ext);

  // quarter-wave lookup, mirrored in odd quadrants, negated in the lower half
  assign phase      = div_rsp.quotient[PHASE_BITS-1:0];
  assign sine_idx   = phase[SINE_IDX_BITS-1:0];
  assign mirror_idx = ~sine_idx + 1'b1;
  always_comb begin
    if (!phase[SINE_IDX_BITS]) begin
      sine_mag = SINE_TABLE[sine_idx];
    end else if (sine_idx == '0) begin
      sine_mag = SINE_BITS'(SINE_PEAK);
    end else begin
      sine_mag = SINE_TABLE[mirror_idx];
    end
  end

  // level sum times peak plus span magnitude times sine, over twice the peak
  assign ab_scaled = (NUM_BITS'(sum_ab) <<< SINE_SHIFT) - NUM_BITS'(sum_ab);
  assign hs        = signed'(NUM_BITS'(mul_rsp.product));
  assign lfo_num   = ab_scaled + (sine_neg_q ? -hs : hs);
  assign lfo_mag   = lfo_num[NUM_BITS-1] ? unsigned'(-lfo_num) : unsigned'(lfo_num);

  // floor of a negative quotient rounds the magnitude up
  assign lfo_q     = div_rsp.quotient[ITER_LFO-1:0];
  assign lfo_q_adj = signed'(SAT_BITS'(lfo_q)) +
                     signed'(SAT_BITS'(num_neg_q && (div_rsp.remainder != '0)));

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (cmd_q) begin
          state_d = ST_EMIT;
        end else begin
          case (mode_q)
            FS_FADING: state_d = (back_in_time && ra_div) ? ST_RA_MUL : ST_FADE_CHK;
            FS_LFO:    state_d = per_zero ? ST_LFO_MUL : ST_LFO_MOD;
            default:   state_d = ST_EMIT;
          endcase
        end
      end
      ST_RA_MUL:   if (mul_rsp.done) state_d = ST_RA_DIV;
      ST_RA_DIV:   if (div_rsp.done) state_d = ST_FADE_CHK;
      ST_FADE_CHK: state_d = fade_stop ? ST_EMIT : ST_FADE_MUL;
      ST_FADE_MUL: if (mul_rsp.done) state_d = ST_FADE_DIV;
      ST_FADE_DIV: if (div_rsp.done) state_d = ST_EMIT;
      ST_LFO_MOD:  if (div_rsp.done) state_d = ST_LFO_PH;
      ST_LFO_PH:   if (div_rsp.done) state_d = ST_LFO_MUL;
      ST_LFO_MUL:  if (mul_rsp.done) state_d = ST_LFO_DIV;
      ST_LFO_DIV:  if (div_rsp.done) state_d = ST_EMIT;
      ST_EMIT:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: datapath controls and state updates
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_d          = mode_q;
    anchor_level_d  = anchor_level_q;
    current_level_d = current_level_q;
    anchor_time_d   = anchor_time_q;
    remaining_d     = remaining_q;
    lvl_d           = lvl_q;
    sine_neg_d      = sine_neg_q;
    num_neg_d       = num_neg_q;
    mul_req         = '0;
    div_req         = '0;

    case (state_q)
      ST_DISPATCH: begin
        if (cmd_q) begin
          // start: anchor at the configured levels and times
          anchor_level_d = start_level_q;
          anchor_time_d  = start_time_q;
          remaining_d    = duration_q;
          if ((duration_q == '0) || (start_level_q == end_level_q)) begin
            mode_d          = FS_STOPPED;
            current_level_d = end_level_q;
            lvl_d           = end_level_q;
          end else if (lfo_mode_q) begin
            mode_d          = FS_LFO;
            current_level_d = '0;
            lvl_d           = LEVEL_BITS'(sum_ab >>> 1);
          end else begin
            mode_d          = FS_FADING;
            current_level_d = start_level_q;
            lvl_d           = start_level_q;
          end
        end else begin
          case (mode_q)
            FS_FADING: begin
              if (back_in_time) begin
                if (ra_div) begin
                  mul_req.start = 1'b1;
                  mul_req.a     = remaining_q;
                  mul_req.b     = un;
                end else begin
                  // ratio of zero or of one needs no division
                  remaining_d    = ratio_ok ? remaining_q : '0;
                  anchor_level_d = current_level_q;
                  anchor_time_d  = now_q;
                end
              end
            end
            FS_LFO: begin
              if (back_in_time) begin
                anchor_time_d = now_q;
              end
              if (per_zero) begin
                // no period: sine term is zero
                sine_neg_d    = 1'b0;
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_BITS'(h);
                mul_req.b     = '0;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_BITS'(el_lfo);
                div_req.divisor  = remaining_q;
                div_req.iters    = DIV_CNT_BITS'(ITER_MOD);
              end
            end
            FS_STOPPED: lvl_d = end_level_q;
            default:    lvl_d = current_level_q;
          endcase
        end
      end

      ST_RA_MUL: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_rsp.product;
          div_req.divisor  = DIV_D_BITS'(ud);
          div_req.iters    = DIV_CNT_BITS'(ITER_REANCHOR);
        end
      end

      ST_RA_DIV: begin
        if (div_rsp.done) begin
          remaining_d    = div_rsp.quotient;
          anchor_level_d = current_level_q;
          anchor_time_d  = now_q;
        end
      end

      ST_FADE_CHK: begin
        if (fade_stop) begin
          mode_d          = FS_STOPPED;
          current_level_d = end_level_q;
          lvl_d           = end_level_q;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = el_fade;
          mul_req.b     = ud;
        end
      end

      ST_FADE_MUL: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_rsp.product;
          div_req.divisor  = remaining_q;
          div_req.iters    = DIV_CNT_BITS'(ITER_FADE);
        end
      end

      ST_FADE_DIV: begin
        if (div_rsp.done) begin
          current_level_d = sat_level(fade_sum);
          lvl_d           = sat_level(fade_sum);
        end
      end

      ST_LFO_MOD: begin
        // phase = remainder scaled to four quadrants of the table
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_N_BITS'({div_rsp.remainder, {PHASE_BITS{1'b0}}});
          div_req.divisor  = remaining_q;
          div_req.iters    = DIV_CNT_BITS'(ITER_PHASE);
        end
      end

      ST_LFO_PH: begin
        if (div_rsp.done) begin
          sine_neg_d    = phase[PHASE_BITS-1];
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_BITS'(h);
          mul_req.b     = MUL_B_BITS'(sine_mag);
        end
      end

      ST_LFO_MUL: begin
        if (mul_rsp.done) begin
          num_neg_d        = lfo_num[NUM_BITS-1];
          div_req.start    = 1'b1;
          div_req.dividend = DIV_N_BITS'(lfo_mag);
          div_req.divisor  = DIV_D_BITS'(LFO_DIVISOR);
          div_req.iters    = DIV_CNT_BITS'(ITER_LFO);
        end
      end

      ST_LFO_DIV: begin
        if (div_rsp.done) begin
          lvl_d = sat_level(num_neg_q ? -lfo_q_adj : lfo_q_adj);
        end
      end

      default: ;
    endcase
  end

  // output slot: loaded from the emit step, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      mode_q          <= FS_DISABLED;
      anchor_level_q  <= '0;
      current_level_q <= '0;
      anchor_time_q   <= '0;
      remaining_q     <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      mode_q          <= mode_d;
      anchor_level_q  <= anchor_level_d;
      current_level_q <= current_level_d;
      anchor_time_q   <= anchor_time_d;
      remaining_q     <= remaining_d;
      out_valid_q     <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= in_word_i.command;
      now_q <= in_word_i.now_time;
    end
    lvl_q      <= lvl_d;
    sine_neg_q <= sine_neg_d;
    num_neg_q  <= num_neg_d;
    if ((state_q == ST_EMIT) && out_free) begin
      out_word_q.level       <= lvl_q;
      out_word_q.fader_state <= mode_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------------------------------------------------------------------
  // shared arithmetic
  // ---------------------------------------------------------------------------
  lfg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  lfg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  `LFG_ASSERT(a_mode_hold_idle, state_q == ST_IDLE |=> $stable(mode_q), "fader state changed while idle")
  `LFG_ASSERT(a_mul_done_wait, mul_rsp.done |-> (state_q == ST_RA_MUL || state_q == ST_FADE_MUL || state_q == ST_LFO_MUL), "multiplier finished outside a wait step")
  `LFG_ASSERT(a_div_done_wait, div_rsp.done |-> (state_q == ST_RA_DIV || state_q == ST_FADE_DIV || state_q == ST_LFO_MOD || state_q == ST_LFO_PH || state_q == ST_LFO_DIV), "divider finished outside a wait step")
  `LFG_ASSERT(a_fade_not_behind, state_q == ST_FADE_CHK |-> now_q >= anchor_time_q, "fade checked before re-anchoring")

endmodule

// File: test/tb_linear_fade_and_lfo_generator.sv
// self-checking bench for the linear fade / sine lfo level generator
// holds its own bit-exact model of the fader; needs lfg_pkg and the generator rtl
module tb_linear_fade_and_lfo_generator;
  import lfg_pkg::*;

  // command codes of an input word
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_START  = 1'b1;

  // quarter-wave sine used by the lfo model
  localparam int          SINE_LEN         = 256;
  localparam longint      SINE_TOP         = 32767;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

  localparam longint LVL_HI = 32767;
  localparam longint LVL_LO = -32768;

  // the slowest word is a sample with time stepped back in a fade
  localparam int SETTLE_CYCLES = 120;
  localparam int SQUEEZE_AT    = 150;
  localparam int SQUEEZE_LEN   = 400;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_WORDS   = 38;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  lfg_in_t                 in_word_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  lfg_out_t                out_word_o;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i = '0;

  linear_fade_and_lfo_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // fader model: register copies, ramp / lfo state and the sine rom
  // ---------------------------------------------------------------------------
  logic signed [15:0] reg_start_lvl  = '0;
  logic signed [15:0] reg_end_lvl    = '0;
  logic [31:0]        reg_duration   = '0;
  logic [31:0]        reg_start_time = '0;
  logic               reg_lfo        = 1'b0;

  longint       anchor_lvl = 0;
  longint       cur_lvl    = 0;
  logic [31:0]  anchor_t   = '0;
  logic [31:0]  remain     = '0;
  fader_state_e mode       = FS_DISABLED;
  logic [15:0]  sine_rom [SINE_LEN];

  // words waiting to be offered, levels waiting to come out
  lfg_in_t  word_q [$];
  lfg_out_t level_q [$];

  bit word_taken;
  bit calm;
  int words_in;
  int send_gap;
  int stall_left;
  int squeeze_left;
  bit squeeze_done;
  int mismatch_cnt;

  // taylor series of sin in q30, rounded to the 15 bit peak
  function automatic void build_sine_rom();
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    for (int i = 0; i < SINE_LEN; i++) begin
      x    = (QUARTER_TURN_Q30 * 64'(i)) / SINE_LEN;
      sum  = x;
      term = x;
      for (int k = 1; k <= 6; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'(SINE_TOP) + (64'd1 << 29)) >> 30;
      if (v > 64'(SINE_TOP)) begin
        v = 64'(SINE_TOP);
      end
      sine_rom[i] = v[15:0];
    end
  endfunction

  function automatic longint div_floor(longint n, longint d);
    if (n >= 0) begin
      return n / d;
    end
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint clip_level(longint v);
    if (v > LVL_HI) begin
      return LVL_HI;
    end
    if (v < LVL_LO) begin
      return LVL_LO;
    end
    return v;
  endfunction

  // full-wave sine from the quarter table, phase in 4*SINE_LEN steps
  function automatic longint sine_of(logic [63:0] phase);
    logic [1:0] quad;
    int         idx;
    longint     s;
    quad = 2'(phase / SINE_LEN);
    idx  = int'(phase % SINE_LEN);
    if (quad == 2'd0 || quad == 2'd2) begin
      s = sine_rom[idx];
    end else if (idx == 0) begin
      s = SINE_TOP;
    end else begin
      s = sine_rom[SINE_LEN - idx];
    end
    return (quad >= 2'd2) ? -s : s;
  endfunction

  function automatic longint lfo_sample(logic [31:0] now);
    longint      lo;
    longint      hi;
    longint      span;
    longint      half;
    longint      s;
    longint      num;
    logic [31:0] gap;
    logic [63:0] r;
    lo   = reg_start_lvl;
    hi   = reg_end_lvl;
    span = hi - lo;
    half = (span < 0) ? -span : span;
    s    = 0;
    // a step back in time just moves the phase origin
    if (now < anchor_t) begin
      anchor_t = now;
    end
    if (remain != 0) begin
      gap = now - anchor_t;
      r   = 64'(gap) % 64'(remain);
      s   = sine_of((r * 64'(4 * SINE_LEN)) / 64'(remain));
    end
    num = (lo + hi) * SINE_TOP + half * s;
    return clip_level(div_floor(num, 2 * SINE_TOP));
  endfunction

  function automatic longint fade_sample(logic [31:0] now);
    longint      target;
    longint      num;
    longint      den;
    longint      d;
    longint      m;
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] rem;
    logic [31:0] el;
    target = reg_end_lvl;
    // time ran backward: re-anchor at the current level and keep the
    // fraction of the ramp that is still left
    if (now < anchor_t) begin
      num = target - cur_lvl;
      den = target - anchor_lvl;
      rem = '0;
      if (den != 0 && ((num < 0) == (den < 0)) && num != 0) begin
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        rem = (un >= ud) ? 64'(remain) : (64'(remain) * un) / ud;
      end
      remain     = rem[31:0];
      anchor_lvl = cur_lvl;
      anchor_t   = now;
    end
    el = now - anchor_t;
    if (remain == 0 || el > remain) begin
      cur_lvl = target;
      mode    = FS_STOPPED;
      return cur_lvl;
    end
    d       = target - anchor_lvl;
    ud      = (d < 0) ? -d : d;
    m       = longint'((ud * 64'(el)) / 64'(remain));
    cur_lvl = clip_level(anchor_lvl + ((d < 0) ? -m : m));
    return cur_lvl;
  endfunction

  // expected level word for one accepted command word
  function automatic lfg_out_t fader_predict(lfg_in_t w);
    lfg_out_t o;
    longint   lo;
    longint   hi;
    longint   lvl;
    if (w.command == CMD_START) begin
      lo         = reg_start_lvl;
      hi         = reg_end_lvl;
      anchor_lvl = lo;
      anchor_t   = reg_start_time;
      remain     = reg_duration;
      if (reg_duration == 0 || lo == hi) begin
        // nothing to ramp over: straight to the target
        cur_lvl = hi;
        mode    = FS_STOPPED;
        lvl     = hi;
      end else if (reg_lfo) begin
        mode    = FS_LFO;
        cur_lvl = 0;
        lvl     = clip_level(div_floor(lo + hi, 2));
      end else begin
        mode    = FS_FADING;
        cur_lvl = lo;
        lvl     = lo;
      end
    end else begin
      case (mode)
        FS_FADING:  lvl = fade_sample(w.now_time);
        FS_LFO:     lvl = lfo_sample(w.now_time);
        FS_STOPPED: lvl = reg_end_lvl;
        default:    lvl = cur_lvl;
      endcase
    end
    o.level       = lvl[15:0];
    o.fader_state = mode;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // pacing: mostly short gaps, a few long ones, none at all in calm phases
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 40);
  endfunction

  // sender: holds a word until it is taken, then waits its gap
  always @(negedge clk_i) begin : drive_words
    logic    offer;
    lfg_in_t word;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offer = in_valid_i && !word_taken;
      word  = in_word_i;
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (word_q.size() != 0) begin
          word     = word_q.pop_front();
          offer    = 1'b1;
          send_gap = pick_gap();
        end
      end
      in_valid_i <= offer;
      in_word_i  <= word;
    end
  end

  // receiver: random stall runs, plus one long squeeze that backs the block
  // up into its input while the sender keeps offering
  always @(negedge clk_i) begin : drive_stall
    logic hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (!squeeze_done && words_in >= SQUEEZE_AT) begin
        squeeze_left = SQUEEZE_LEN;
        squeeze_done = 1'b1;
      end
      hold = 1'b0;
      if (squeeze_left > 0) begin
        hold = 1'b1;
        squeeze_left--;
      end else if (stall_left > 0) begin
        hold = 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      out_stall_i <= hold;
    end
  end

  task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    // one line per mismatch, every one counted
    $display("%0t  %s: expected %h, got %h", $realtime, what, want, got);
    mismatch_cnt++;
  endtask

  // monitor: predicts on every accepted command word, checks every level word
  always @(posedge clk_i) begin : watch
    lfg_out_t want;
    word_taken = rst_ni && in_valid_i && !in_stall_o;
    if (word_taken) begin
      level_q.push_back(fader_predict(in_word_i));
      words_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (level_q.size() == 0) begin
        note_mismatch("level word with nothing expected", '0, out_word_o.level);
      end else begin
        want = level_q.pop_front();
        if (out_word_o.level !== want.level) begin
          note_mismatch("level", want.level, out_word_o.level);
        end
        if (out_word_o.fader_state !== want.fader_state) begin
          note_mismatch("fader_state", 16'(want.fader_state), 16'(out_word_o.fader_state));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_word(logic cmd, logic [31:0] t);
    lfg_in_t w;
    w.command  = cmd;
    w.now_time = t;
    word_q.push_back(w);
  endfunction

  // register write; the block is idle so the model copy follows at once
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_START_LEVEL: reg_start_lvl  = data[15:0];
      CFG_END_LEVEL:   reg_end_lvl    = data[15:0];
      CFG_DURATION:    reg_duration   = data;
      CFG_START_TIME:  reg_start_time = data;
      CFG_LFO_MODE:    reg_lfo        = data[0];
      default: ;
    endcase
  endtask

  // level and mode writes carry junk above the register width
  task automatic set_fader(logic [15:0] lo, logic [15:0] hi, logic [31:0] dur,
                           logic [31:0] t0, logic lfo);
    write_reg(CFG_START_LEVEL, {16'($urandom), lo});
    write_reg(CFG_END_LEVEL, {16'($urandom), hi});
    write_reg(CFG_DURATION, dur);
    write_reg(CFG_START_TIME, t0);
    write_reg(CFG_LFO_MODE, {31'($urandom), lfo});
  endtask

  // wait until every word is in and every level word is out
  task automatic drain();
    while (word_q.size() != 0 || in_valid_i || level_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic logic [15:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 16'h8000;
    end
    if (r < 30) begin
      return 16'h7fff;
    end
    if (r < 40) begin
      return 16'h0000;
    end
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return '0;
    end
    if (r < 70) begin
      return $urandom_range(1, 2000);
    end
    if (r < 85) begin
      return $urandom_range(2001, 1 << 20);
    end
    if (r < 93) begin
      return $urandom;
    end
    return 32'hffff_ffff;
  endfunction

  initial begin : stimulus
    logic [15:0] lo;
    logic [15:0] hi;
    logic [31:0] dur;
    logic [31:0] t0;
    logic [31:0] t;
    int          r;
    build_sine_rom();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // out of reset: disabled, then a start with zero duration stops at once
    calm = 1'b1;
    queue_word(CMD_SAMPLE, 32'h0000_0000);
    queue_word(CMD_START, 32'hffff_ffff);
    queue_word(CMD_SAMPLE, 32'hffff_ffff);
    drain();

    // full-scale rising fade, sampled through its end
    set_fader(16'h8000, 16'h7fff, 32'd1000, 32'd100, 1'b0);
    queue_word(CMD_START, 32'd7);
    queue_word(CMD_SAMPLE, 32'd100);
    queue_word(CMD_SAMPLE, 32'd600);
    queue_word(CMD_SAMPLE, 32'd1100);
    queue_word(CMD_SAMPLE, 32'd1101);
    drain();

    // falling fade over the longest duration, with time jumping back
    calm = 1'b0;
    set_fader(16'h7fff, 16'h8000, 32'hffff_ffff, 32'h8000_0000, 1'b0);
    queue_word(CMD_START, 32'h0);
    queue_word(CMD_SAMPLE, 32'hc000_0000);
    queue_word(CMD_SAMPLE, 32'h0000_0010);
    queue_word(CMD_SAMPLE, 32'hffff_ffff);
    drain();

    // target moved after the fade has stopped: read live on the next sample
    write_reg(CFG_END_LEVEL, 32'h0000_0000);
    queue_word(CMD_SAMPLE, 32'h0000_0008);
    drain();

    // equal levels: zero span stops at once
    set_fader(16'd12345, 16'd12345, 32'd5, 32'd0, 1'b0);
    queue_word(CMD_START, 32'd1);
    queue_word(CMD_SAMPLE, 32'd2);
    drain();

    // lfo across a 1024 tick period, one sample per quadrant, then a step back
    set_fader(16'h8000, 16'h7fff, 32'd1024, 32'd4096, 1'b1);
    queue_word(CMD_START, 32'd0);
    queue_word(CMD_SAMPLE, 32'd4096);
    queue_word(CMD_SAMPLE, 32'd4352);
    queue_word(CMD_SAMPLE, 32'd4608);
    queue_word(CMD_SAMPLE, 32'd4864 + 32'd255);
    queue_word(CMD_SAMPLE, 32'd10);
    drain();

    // unmapped register slots must not disturb anything
    for (int k = 0; k < 3; k++) begin
      write_reg(CFG_IDX_BITS'(CFG_LFO_MODE) + CFG_IDX_BITS'(k + 1), $urandom);
    end
    // inverted lfo over the longest period
    set_fader(16'h7fff, 16'h8000, 32'hffff_ffff, 32'h0, 1'b1);
    queue_word(CMD_START, 32'h1234_5678);
    queue_word(CMD_SAMPLE, 32'hffff_fffe);
    queue_word(CMD_SAMPLE, 32'h3fff_ffff);
    drain();

    // random phases: a start, then a time walk that mostly moves forward
    // through the ramp, with some steps back, noise times and restarts
    for (int p = 0; p < RAND_PHASES; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      lo   = pick_level();
      hi   = ($urandom_range(0, 9) == 0) ? lo : pick_level();
      dur  = pick_duration();
      t0   = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
      if (p > 0 && $urandom_range(0, 3) == 0) begin
        // keep the running fade or lfo and only move its bounds
        write_reg(CFG_START_LEVEL, {16'($urandom), lo});
        write_reg(CFG_END_LEVEL, {16'($urandom), hi});
        t = $urandom;
      end else begin
        set_fader(lo, hi, dur, t0, 1'($urandom_range(0, 1)));
        queue_word(CMD_START, $urandom);
        t = t0 - 32'($urandom_range(0, 3));
      end
      for (int n = 1; n < PHASE_WORDS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 74) begin
          t = t + 32'($urandom_range(0, reg_duration / 6 + 1));
          queue_word(CMD_SAMPLE, t);
        end else if (r < 84) begin
          t = t - 32'($urandom_range(0, reg_duration / 4 + 1));
          queue_word(CMD_SAMPLE, t);
        end else if (r < 92) begin
          t = $urandom;
          queue_word(CMD_SAMPLE, t);
        end else begin
          queue_word(CMD_START, $urandom);
          t = reg_start_time;
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hung handshake guard, several times the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: linear_fade_and_lfo_generator.f
+incdir+hdl
hdl/lfg_pkg.sv
hdl/lfg_mul.sv
hdl/lfg_div.sv
hdl/linear_fade_and_lfo_generator.sv
test/tb_linear_fade_and_lfo_generator.sv
